>>> hw/rtl/multi_heap_priority_queue_assert.svh
// Assertion macros used by the checker file of the priority queue.
`ifndef MULTI_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MULTI_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MHPQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mhpq: implication check failed");

// Next-cycle implication, checked out of reset.
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mhpq: next-cycle check failed");

`endif

>>> hw/rtl/mhpq_pkg.sv
// Shared constants, types and helpers of the multi-heap priority queue.
`default_nettype none
package mhpq_pkg;

	localparam int NUM_HEAPS   = 16;
	localparam int HEAP_DEPTH  = 1024;
	localparam int MAX_ITEMS   = 1048576;
	localparam int STORE_SIZE  = NUM_HEAPS * HEAP_DEPTH;
	localparam int CAP_SINGLE  = (STORE_SIZE < MAX_ITEMS) ? STORE_SIZE : MAX_ITEMS;
	localparam int CAP_STATION = (HEAP_DEPTH < MAX_ITEMS) ? HEAP_DEPTH : MAX_ITEMS;

	localparam int ADDR_W  = $clog2(STORE_SIZE);
	localparam int HEAP_W  = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
	localparam int CNT_W   = $clog2(CAP_SINGLE + 1);
	localparam int UB_W    = 5;
	localparam int KEY_W   = 32;
	localparam int IDX_W   = 20;
	localparam int SEL_W   = 4;
	localparam int ENTRY_W = KEY_W + IDX_W;
	localparam int REG_W   = 1;

	// Register indexes
	localparam logic [REG_W-1:0] REG_MODE  = 1'b0;
	localparam logic [REG_W-1:0] REG_BOUND = 1'b1;

	// Outcome codes
	localparam logic [1:0] OUT_DONE   = 2'd0;
	localparam logic [1:0] OUT_EMPTY  = 2'd1;
	localparam logic [1:0] OUT_FULL   = 2'd2;
	localparam logic [1:0] OUT_REJECT = 2'd3;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_REJECT
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [HEAP_W-1:0]       heap;
		logic [ENTRY_W-1:0]      entry;
	} req_t;

	typedef struct packed {
		logic            per_station;
		logic [UB_W-1:0] ub;
	} cfg_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [ENTRY_W-1:0] wdata;
		logic [ADDR_W-1:0]  raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_INS_UP,
		B_INS_CMP,
		B_NORM,
		B_SCAN,
		B_DEL_ROOT,
		B_DEL_LAST,
		B_DEL_LOAD,
		B_DEL_CHK,
		B_DEL_RL,
		B_DEL_RR
	} back_state_t;

	// Signed key order of two stored entries: a strictly larger than b
	function automatic logic key_gt(input logic [ENTRY_W-1:0] a, input logic [ENTRY_W-1:0] b);
		return $signed(a[ENTRY_W-1:IDX_W]) > $signed(b[ENTRY_W-1:IDX_W]);
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/multi_heap_priority_queue.sv
// Top level of the multi-heap priority queue.
// Binary min-heaps of (Q16.16 key, item index) pairs in one 16384-entry store.
// Input stream (s_*): one request per transfer; s_tuser[0] selects insert (0)
// or remove-minimum (1). Output stream (m_*): exactly one result per request,
// in request order. Configuration: cfg_we/cfg_index/cfg_wdata, index 0 is the
// per-station mode (a change empties all heaps), index 1 the station bound;
// write only while the block is idle.
// An accepted request is in the two-entry queue from the next cycle. An insert
// climbs from the new leaf, moving each larger parent down; a removal reads the
// root and the last entry and sifts down, reading the children at each level;
// in per-station mode the round-robin pointer step and the search of heap counts
// (one heap per cycle) come first. The heap memory's write port and registered
// read port set the per-level cost. Reset clears all heap counts and the
// round-robin pointer and sets the mode to single-heap and the bound to 16; no
// memory clearing is needed. If the receiver stalls, the result is held in the
// output register and the front queue keeps taking up to two requests.
`default_nettype none
module multi_heap_priority_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [55:0]                  s_tdata,  // key[31:0], item_index[51:32], heap_select[55:52]
	input  wire logic [0:0]                   s_tuser,  // func[0]
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [23:0]                       m_tdata,  // removed_index[19:0], zero fill
	output logic [2:0]                        m_tuser,  // removed_valid[0], outcome[2:1]
	input  wire logic                         cfg_we,
	input  wire logic [mhpq_pkg::REG_W-1:0]   cfg_index,
	input  wire logic [mhpq_pkg::UB_W-1:0]    cfg_wdata
);

	mhpq_pkg::cfg_t                 cfg;
	logic                           q_valid;
	mhpq_pkg::req_t                 q_req;
	logic                           q_pop;
	mhpq_pkg::mem_req_t             mem;
	logic [mhpq_pkg::ENTRY_W-1:0]   mem_rdata;
	logic [mhpq_pkg::IDX_W-1:0]     out_index;
	logic                           out_valid;
	logic [1:0]                     out_outcome;

	mhpq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	mhpq_store u_store (
		.clk   (clk),
		.mem   (mem),
		.rdata (mem_rdata)
	);

	mhpq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.cfg         (cfg),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.q_pop       (q_pop),
		.mem         (mem),
		.mem_rdata   (mem_rdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_index   (out_index),
		.out_valid   (out_valid),
		.out_outcome (out_outcome)
	);

	// result packing
	assign m_tdata = {4'd0, out_index};
	assign m_tuser = {out_outcome, out_valid};

endmodule
`default_nettype wire

>>> hw/rtl/mhpq_store.sv
// Heap entry memory: one write port, one registered read port.
`default_nettype none
module mhpq_store (
	input  wire logic                         clk,
	input  wire mhpq_pkg::mem_req_t           mem,
	output logic [mhpq_pkg::ENTRY_W-1:0]      rdata
);

	logic [mhpq_pkg::ENTRY_W-1:0] mem_q [mhpq_pkg::STORE_SIZE];

	// write port
	always_ff @(posedge clk) begin
		if (mem.we) begin
			mem_q[mem.waddr] <= mem.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[mem.raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/mhpq_front.sv
// Front end: takes input requests, classifies them and queues them for the back end.
`default_nettype none
module mhpq_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [55:0]            s_tdata,
	input  wire logic [0:0]             s_tuser,
	input  wire mhpq_pkg::cfg_t         cfg,
	output logic                        q_valid,
	output mhpq_pkg::req_t              q_req,
	input  wire logic                   q_pop
);

	localparam logic FUNC_REMOVE = 1'b1;

	mhpq_pkg::req_t                 fifo_q [2];
	logic                           wr_q;
	logic                           rd_q;
	logic [1:0]                     cnt_q;
	logic                           push;
	logic [mhpq_pkg::SEL_W-1:0]     sel;
	logic                           reject;
	mhpq_pkg::req_t                 cls;

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = fifo_q[rd_q];

	// classify the request
	assign sel    = s_tdata[55:52];
	assign reject = (mhpq_pkg::UB_W'(sel) > cfg.ub) ||
	                (mhpq_pkg::UB_W'(sel) >= mhpq_pkg::UB_W'(mhpq_pkg::NUM_HEAPS));

	// stored entry: key in the upper bits, item index in the lower bits
	always_comb begin
		cls.entry = {s_tdata[31:0], s_tdata[51:32]};
		cls.heap  = '0;
		if (s_tuser[0] == FUNC_REMOVE) begin
			cls.op = mhpq_pkg::OP_REMOVE;
		end else if (cfg.per_station && reject) begin
			cls.op = mhpq_pkg::OP_REJECT;
		end else begin
			cls.op = mhpq_pkg::OP_INSERT;
			if (cfg.per_station) begin
				cls.heap = mhpq_pkg::HEAP_W'(sel);
			end
		end
	end

	// two-entry request queue, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cls;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/mhpq_back.sv
// Back end: configuration, heap counts, sift sequencer and result register.
`default_nettype none
module mhpq_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mhpq_pkg::REG_W-1:0]        cfg_index,
	input  wire logic [mhpq_pkg::UB_W-1:0]         cfg_wdata,
	output mhpq_pkg::cfg_t                         cfg,
	input  wire logic                              q_valid,
	input  wire mhpq_pkg::req_t                    q_req,
	output logic                                   q_pop,
	output mhpq_pkg::mem_req_t                     mem,
	input  wire logic [mhpq_pkg::ENTRY_W-1:0]      mem_rdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [mhpq_pkg::IDX_W-1:0]             out_index,
	output logic                                   out_valid,
	output logic [1:0]                             out_outcome
);

	localparam int CW = mhpq_pkg::CNT_W;
	localparam int UW = mhpq_pkg::UB_W;
	localparam int HW = mhpq_pkg::HEAP_W;

	mhpq_pkg::back_state_t          state_q, state_nx;
	logic                           mode_q;
	logic [UW-1:0]                  bound_q;
	logic [UW-1:0]                  ub;
	logic                           mode_chg;
	logic [CW-1:0]                  cnt_q [mhpq_pkg::NUM_HEAPS];
	logic [HW-1:0]                  ptr_q;
	logic [HW-1:0]                  h_q;
	logic [CW-1:0]                  pos_q;
	logic [CW-1:0]                  n_q;
	logic [UW-1:0]                  m_q;
	logic [UW-1:0]                  i_q;
	logic [mhpq_pkg::ENTRY_W-1:0]   ent_q;
	logic [mhpq_pkg::ENTRY_W-1:0]   lch_q;
	logic [mhpq_pkg::IDX_W-1:0]     res_idx_q;
	logic                           m_tvalid_q;
	logic [mhpq_pkg::IDX_W-1:0]     out_index_q;
	logic                           out_valid_q;
	logic [1:0]                     out_outcome_q;

	logic [HW-1:0]                  rd_h;
	logic [CW-1:0]                  cnt_rd;
	logic                           cnt_we;
	logic [CW-1:0]                  cnt_wd;
	logic [CW-1:0]                  cap;
	logic                           full;
	logic                           out_free;
	logic [HW-1:0]                  h_next;
	logic                           scan_last;
	logic [CW-1:0]                  c2;
	logic                           has_r;
	logic                           pick_r;
	logic [mhpq_pkg::ENTRY_W-1:0]   child;
	logic [CW-1:0]                  cpos;
	logic                           ins_gt;
	logic                           down_gt;
	logic                           fin;
	logic                           fin_valid;
	logic [1:0]                     fin_outcome;

	function automatic logic [mhpq_pkg::ADDR_W-1:0] addr_of(input logic per,
		input logic [HW-1:0] h, input logic [CW-1:0] p);
		logic [mhpq_pkg::ADDR_W-1:0] off;
		off = mhpq_pkg::ADDR_W'(p - 1'b1);
		return per ? mhpq_pkg::ADDR_W'(h) * mhpq_pkg::ADDR_W'(mhpq_pkg::HEAP_DEPTH) + off : off;
	endfunction

	// configuration registers
	assign mode_chg = cfg_we && (cfg_index == mhpq_pkg::REG_MODE) && (cfg_wdata[0] != mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			bound_q <= UW'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mhpq_pkg::REG_MODE:  mode_q  <= cfg_wdata[0];
				mhpq_pkg::REG_BOUND: bound_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// bound clamped to 1..NUM_HEAPS
	always_comb begin
		if (bound_q == '0) begin
			ub = UW'(1);
		end else if (bound_q > UW'(mhpq_pkg::NUM_HEAPS)) begin
			ub = UW'(mhpq_pkg::NUM_HEAPS);
		end else begin
			ub = bound_q;
		end
	end

	assign cfg.per_station = mode_q;
	assign cfg.ub          = ub;

	// shared datapath terms
	assign out_free  = !m_tvalid_q || m_tready;
	assign q_pop     = (state_q == mhpq_pkg::B_IDLE) && q_valid && out_free;
	assign rd_h      = (state_q == mhpq_pkg::B_IDLE) ? q_req.heap : h_q;
	assign cnt_rd    = cnt_q[rd_h];
	assign cap       = mode_q ? CW'(mhpq_pkg::CAP_STATION) : CW'(mhpq_pkg::CAP_SINGLE);
	assign full      = (cnt_rd >= cap);
	assign h_next    = (UW'(h_q) + UW'(1) == ub) ? '0 : h_q + 1'b1;
	assign scan_last = (i_q == ub - UW'(1));
	assign c2        = {pos_q[CW-2:0], 1'b0};
	assign has_r     = (c2 < n_q);
	assign pick_r    = mhpq_pkg::key_gt(lch_q, mem_rdata);
	assign ins_gt    = mhpq_pkg::key_gt(mem_rdata, ent_q);

	always_comb begin
		if (state_q == mhpq_pkg::B_DEL_RR && pick_r) begin
			child = mem_rdata;
			cpos  = c2 + 1'b1;
		end else if (state_q == mhpq_pkg::B_DEL_RR) begin
			child = lch_q;
			cpos  = c2;
		end else begin
			child = mem_rdata;
			cpos  = c2;
		end
	end
	assign down_gt = mhpq_pkg::key_gt(ent_q, child);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mhpq_pkg::B_IDLE: begin
				if (q_pop) begin
					case (q_req.op)
						mhpq_pkg::OP_INSERT: if (!full) state_nx = mhpq_pkg::B_INS_UP;
						mhpq_pkg::OP_REMOVE: begin
							if (mode_q) state_nx = mhpq_pkg::B_NORM;
							else if (cnt_rd != '0) state_nx = mhpq_pkg::B_DEL_ROOT;
						end
						default: ;
					endcase
				end
			end
			mhpq_pkg::B_INS_UP:
				state_nx = (pos_q > CW'(1)) ? mhpq_pkg::B_INS_CMP : mhpq_pkg::B_IDLE;
			mhpq_pkg::B_INS_CMP:
				state_nx = ins_gt ? mhpq_pkg::B_INS_UP : mhpq_pkg::B_IDLE;
			mhpq_pkg::B_NORM:
				if (m_q < ub) state_nx = mhpq_pkg::B_SCAN;
			mhpq_pkg::B_SCAN: begin
				if (cnt_rd != '0) state_nx = mhpq_pkg::B_DEL_ROOT;
				else if (scan_last) state_nx = mhpq_pkg::B_IDLE;
			end
			mhpq_pkg::B_DEL_ROOT: state_nx = mhpq_pkg::B_DEL_LAST;
			mhpq_pkg::B_DEL_LAST: state_nx = mhpq_pkg::B_DEL_LOAD;
			mhpq_pkg::B_DEL_LOAD: state_nx = mhpq_pkg::B_DEL_CHK;
			mhpq_pkg::B_DEL_CHK: begin
				if (n_q == '0) state_nx = mhpq_pkg::B_IDLE;
				else if (pos_q <= (n_q >> 1)) state_nx = mhpq_pkg::B_DEL_RL;
				else state_nx = mhpq_pkg::B_IDLE;
			end
			mhpq_pkg::B_DEL_RL: begin
				if (has_r) state_nx = mhpq_pkg::B_DEL_RR;
				else state_nx = down_gt ? mhpq_pkg::B_DEL_CHK : mhpq_pkg::B_IDLE;
			end
			mhpq_pkg::B_DEL_RR:
				state_nx = down_gt ? mhpq_pkg::B_DEL_CHK : mhpq_pkg::B_IDLE;
			default: state_nx = mhpq_pkg::B_IDLE;
		endcase
	end

	// outputs: memory requests, count updates, completion
	always_comb begin
		mem.we      = 1'b0;
		mem.waddr   = addr_of(mode_q, h_q, pos_q);
		mem.wdata   = ent_q;
		mem.raddr   = addr_of(mode_q, h_q, pos_q);
		cnt_we      = 1'b0;
		cnt_wd      = cnt_rd;
		fin         = 1'b0;
		fin_valid   = 1'b0;
		fin_outcome = mhpq_pkg::OUT_DONE;
		unique case (state_q)
			mhpq_pkg::B_IDLE: begin
				if (q_pop) begin
					case (q_req.op)
						mhpq_pkg::OP_INSERT: begin
							if (full) begin
								fin         = 1'b1;
								fin_outcome = mhpq_pkg::OUT_FULL;
							end else begin
								cnt_we = 1'b1;
								cnt_wd = cnt_rd + 1'b1;
							end
						end
						mhpq_pkg::OP_REMOVE: begin
							if (!mode_q && cnt_rd == '0) begin
								fin         = 1'b1;
								fin_outcome = mhpq_pkg::OUT_EMPTY;
							end
						end
						default: begin
							fin         = 1'b1;
							fin_outcome = mhpq_pkg::OUT_REJECT;
						end
					endcase
				end
			end
			mhpq_pkg::B_INS_UP: begin
				if (pos_q > CW'(1)) begin
					mem.raddr = addr_of(mode_q, h_q, pos_q >> 1);
				end else begin
					mem.we = 1'b1;
					fin    = 1'b1;
				end
			end
			mhpq_pkg::B_INS_CMP: begin
				mem.we = 1'b1;
				if (ins_gt) begin
					mem.wdata = mem_rdata;
				end else begin
					fin = 1'b1;
				end
			end
			mhpq_pkg::B_NORM: ;
			mhpq_pkg::B_SCAN: begin
				if (cnt_rd == '0 && scan_last) begin
					fin         = 1'b1;
					fin_outcome = mhpq_pkg::OUT_EMPTY;
				end
			end
			mhpq_pkg::B_DEL_ROOT: begin
				mem.raddr = addr_of(mode_q, h_q, CW'(1));
				cnt_we    = 1'b1;
				cnt_wd    = cnt_rd - 1'b1;
			end
			mhpq_pkg::B_DEL_LAST: mem.raddr = addr_of(mode_q, h_q, n_q + 1'b1);
			mhpq_pkg::B_DEL_LOAD: ;
			mhpq_pkg::B_DEL_CHK: begin
				if (n_q == '0) begin
					fin       = 1'b1;
					fin_valid = 1'b1;
				end else if (pos_q <= (n_q >> 1)) begin
					mem.raddr = addr_of(mode_q, h_q, c2);
				end else begin
					mem.we    = 1'b1;
					fin       = 1'b1;
					fin_valid = 1'b1;
				end
			end
			mhpq_pkg::B_DEL_RL, mhpq_pkg::B_DEL_RR: begin
				if (state_q == mhpq_pkg::B_DEL_RL && has_r) begin
					mem.raddr = addr_of(mode_q, h_q, c2 + 1'b1);
				end else begin
					mem.we = 1'b1;
					if (down_gt) begin
						mem.wdata = child;
					end else begin
						fin       = 1'b1;
						fin_valid = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mhpq_pkg::B_IDLE;
			ptr_q      <= '0;
			m_tvalid_q <= 1'b0;
			for (int k = 0; k < mhpq_pkg::NUM_HEAPS; k++) cnt_q[k] <= '0;
		end else begin
			state_q <= state_nx;
			if (fin) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (mode_chg) begin
				ptr_q <= '0;
				for (int k = 0; k < mhpq_pkg::NUM_HEAPS; k++) cnt_q[k] <= '0;
			end else begin
				if (cnt_we) cnt_q[rd_h] <= cnt_wd;
				if (state_q == mhpq_pkg::B_SCAN) begin
					if (cnt_rd != '0) ptr_q <= h_q;
					else if (scan_last) ptr_q <= h_next;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			mhpq_pkg::B_IDLE: begin
				h_q   <= q_req.heap;
				ent_q <= q_req.entry;
				pos_q <= cnt_rd + 1'b1;
				m_q   <= UW'(ptr_q) + UW'(1);
			end
			mhpq_pkg::B_INS_CMP: if (ins_gt) pos_q <= pos_q >> 1;
			mhpq_pkg::B_NORM: begin
				if (m_q >= ub) begin
					m_q <= m_q - ub;
				end else begin
					h_q <= HW'(m_q);
					i_q <= '0;
				end
			end
			mhpq_pkg::B_SCAN: begin
				if (cnt_rd == '0) begin
					h_q <= h_next;
					i_q <= i_q + 1'b1;
				end
			end
			mhpq_pkg::B_DEL_ROOT: n_q <= cnt_rd - 1'b1;
			mhpq_pkg::B_DEL_LAST: res_idx_q <= mem_rdata[mhpq_pkg::IDX_W-1:0];
			mhpq_pkg::B_DEL_LOAD: begin
				ent_q <= mem_rdata;
				pos_q <= CW'(1);
			end
			mhpq_pkg::B_DEL_RL: begin
				lch_q <= mem_rdata;
				if (!has_r && down_gt) pos_q <= cpos;
			end
			mhpq_pkg::B_DEL_RR: if (down_gt) pos_q <= cpos;
			default: ;
		endcase
		if (fin) begin
			out_index_q   <= fin_valid ? res_idx_q : '0;
			out_valid_q   <= fin_valid;
			out_outcome_q <= fin_outcome;
		end
	end

	assign m_tvalid    = m_tvalid_q;
	assign out_index   = out_index_q;
	assign out_valid   = out_valid_q;
	assign out_outcome = out_outcome_q;

endmodule
`default_nettype wire

>>> hw/rtl/mhpq_checker.sv
// Port-level checks of the priority queue, bound to the top level.
`default_nettype none
`include "multi_heap_priority_queue_assert.svh"
module mhpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// a stalled result holds
	`MHPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// a returned item always comes with the done outcome
	`MHPQ_ASSERT_IMPL(a_valid_done, m_tvalid && m_tuser[0], m_tuser[2:1] == mhpq_pkg::OUT_DONE)
	// no item returned means a zero index
	`MHPQ_ASSERT_IMPL(a_idx_zero, m_tvalid && !m_tuser[0], m_tdata == 24'd0)

endmodule

bind multi_heap_priority_queue mhpq_checker u_chk (.*);
`default_nettype wire
